// ===== hw/rtl/interp_table_position_lookup_defines.svh =====
// Assertion macros for the interpolation lookup table block.
`ifndef INTERP_TABLE_POSITION_LOOKUP_DEFINES_SVH
`define INTERP_TABLE_POSITION_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ITPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/itpl_pkg.sv =====
// Shared types and constants of the interpolation lookup table block.
`timescale 1ns / 1ps

package itpl_pkg;

    localparam int DEPTH      = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int VAL_W      = 32;
    localparam int TOL_W      = 31;
    localparam int ENTRY_W    = 2 * VAL_W + TOL_W;
    localparam int IN_W       = 136;
    localparam int OUT_W      = 88;
    localparam int CFG_DATA_W = 7;
    localparam int STEP_W     = 6;
    localparam logic [STEP_W-1:0] MUL_LAST = 6'd31;
    localparam logic [STEP_W-1:0] DIV_LAST = 6'd63;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_TABLE_READY = 1'b1;

    typedef enum logic [2:0] {
        ACT_WRITE     = 3'd0,
        ACT_FWD       = 3'd1,
        ACT_REV       = 3'd2,
        ACT_INDEX     = 3'd3,
        ACT_TWK_FWD   = 3'd4,
        ACT_TWK_BACK  = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_INDEX_REJ = 3'd2,
        ST_NO_STEP   = 3'd3,
        ST_ZERO_SPAN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_LOOKUP,
        KIND_TARGET
    } kind_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_LAST,
        RD_WALK,
        RD_SEG,
        RD_SEG1,
        RD_TGT
    } rdsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD0,
        S_CK0,
        S_RDL,
        S_CKL,
        S_WRD,
        S_WCK,
        S_SEGA,
        S_SEGB,
        S_SEGC,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_ACC,
        S_TGT_RD,
        S_TGT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic   latch;
        logic   decode;
        rdsel_t rd_sel;
        logic   ld_prev;
        logic   seg_first;
        logic   seg_last;
        logic   seg_walk;
        logic   walk_init;
        logic   walk_inc;
        logic   ld_a;
        logic   ld_b;
        logic   setup;
        logic   mul_step;
        logic   div_step;
        logic   acc;
        logic   ld_tgt;
        logic   finish;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  q_lt_key;
        logic  bracket;
        logic  walk_end;
        logic  zero_span;
        logic  cnt_done;
        logic  out_free;
    } sts_t;

endpackage

// ===== hw/rtl/itpl_dp.sv =====
// Datapath: table memory, walk registers, serial multiplier and divider, result register.
`timescale 1ns / 1ps

module itpl_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [itpl_pkg::IN_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [itpl_pkg::OUT_W-1:0]        m_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [itpl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  itpl_pkg::cmd_t                    cmd,
    output itpl_pkg::sts_t                    sts
);

    logic [itpl_pkg::ENTRY_W-1:0] mem [itpl_pkg::DEPTH];
    logic [itpl_pkg::ENTRY_W-1:0] rd_reg;
    logic [itpl_pkg::IDX_W-1:0]   rd_addr;

    logic [2:0]                   action_reg;
    logic [itpl_pkg::IDX_W-1:0]   pidx_reg;
    logic signed [31:0]           xin_reg, yin_reg, q_reg;
    logic [itpl_pkg::TOL_W-1:0]   tolin_reg;

    logic [itpl_pkg::CNT_W-1:0]   pcount_reg;
    logic                         ready_reg;

    logic                         key_y_reg;
    logic [itpl_pkg::CNT_W-1:0]   j_reg;
    logic [itpl_pkg::IDX_W-1:0]   seg_reg, tgt_idx_reg;
    logic signed [31:0]           prev_reg;
    logic [itpl_pkg::ENTRY_W-1:0] ea_reg, eb_reg;

    logic [31:0]                  m1_reg, d_reg, rem_reg;
    logic [63:0]                  prod_reg;
    logic                         neg_reg;
    logic signed [31:0]           base_reg;
    logic [itpl_pkg::STEP_W-1:0]  cnt_reg;

    logic [2:0]                   st_reg;
    logic signed [31:0]           readback_reg, tgt_reg;
    logic [6:0]                   lm_reg;
    logic                         tv_reg;
    logic [itpl_pkg::IDX_W-1:0]   sel_reg;
    logic                         m_tvalid_reg;
    logic [itpl_pkg::OUT_W-1:0]   m_tdata_reg;

    logic [itpl_pkg::CNT_W-1:0]   n;
    logic                         ready1, ready2;
    logic [itpl_pkg::IDX_W-1:0]   n_last;
    logic signed [31:0]           rd_x, rd_y, key;
    logic signed [31:0]           xa, ya, xb, yb, a0, a1, b0, b1;
    logic [itpl_pkg::TOL_W-1:0]   ta, tb;
    logic signed [32:0]           dm1, dm2, dd, dq0, dq1;
    logic [31:0]                  mag1, mag2, magd, magq0, magq1;

    logic [32:0]                  mul_sum, div_shift;
    logic                         div_ge;
    logic                         quo_big;
    logic signed [36:0]           acc_sum;
    logic signed [31:0]           acc_res;

    itpl_pkg::kind_t              dec_kind;
    logic [2:0]                   dec_st;
    logic [itpl_pkg::IDX_W-1:0]   dec_idx;
    logic                         dec_sel;
    logic                         out_free;

    assign n      = (pcount_reg > 7'(itpl_pkg::DEPTH)) ? 7'(itpl_pkg::DEPTH) : pcount_reg;
    assign ready1 = ready_reg && (n != 7'd0);
    assign ready2 = ready_reg && (n > 7'd1);
    assign n_last = 6'(n - 7'd1);

    assign rd_x = rd_reg[31:0];
    assign rd_y = rd_reg[63:32];
    assign key  = key_y_reg ? rd_y : rd_x;

    assign xa = ea_reg[31:0];
    assign ya = ea_reg[63:32];
    assign ta = ea_reg[94:64];
    assign xb = eb_reg[31:0];
    assign yb = eb_reg[63:32];
    assign tb = eb_reg[94:64];
    assign a0 = key_y_reg ? ya : xa;
    assign a1 = key_y_reg ? yb : xb;
    assign b0 = key_y_reg ? xa : ya;
    assign b1 = key_y_reg ? xb : yb;

    assign dm1   = 33'(b1) - 33'(b0);
    assign dm2   = 33'(q_reg) - 33'(a0);
    assign dd    = 33'(a1) - 33'(a0);
    assign dq0   = 33'(q_reg) - 33'(xa);
    assign dq1   = 33'(q_reg) - 33'(xb);
    assign mag1  = dm1[32] ? 32'(-dm1) : dm1[31:0];
    assign mag2  = dm2[32] ? 32'(-dm2) : dm2[31:0];
    assign magd  = dd[32]  ? 32'(-dd)  : dd[31:0];
    assign magq0 = dq0[32] ? 32'(-dq0) : dq0[31:0];
    assign magq1 = dq1[32] ? 32'(-dq1) : dq1[31:0];

    assign mul_sum   = {1'b0, prod_reg[63:32]} + (prod_reg[0] ? {1'b0, m1_reg} : 33'd0);
    assign div_shift = {rem_reg, prod_reg[63]};
    assign div_ge    = div_shift >= {1'b0, d_reg};

    assign quo_big = (prod_reg[63:35] != '0) || (prod_reg[34] && (prod_reg[33:0] != '0));
    assign acc_sum = neg_reg ? (37'(base_reg) - {2'b00, prod_reg[34:0]})
                             : (37'(base_reg) + {2'b00, prod_reg[34:0]});

    always_comb begin
        if (quo_big) begin
            acc_res = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (acc_sum > 37'sh0_7fff_ffff) begin
            acc_res = 32'sh7fff_ffff;
        end else if (acc_sum < -37'sh0_8000_0000) begin
            acc_res = 32'sh8000_0000;
        end else begin
            acc_res = acc_sum[31:0];
        end
    end

    always_comb begin
        dec_kind = itpl_pkg::KIND_DONE;
        dec_st   = itpl_pkg::ST_OK;
        dec_idx  = pidx_reg;
        dec_sel  = 1'b0;
        unique case (action_reg)
            itpl_pkg::ACT_WRITE: begin
                dec_kind = itpl_pkg::KIND_DONE;
            end
            itpl_pkg::ACT_FWD, itpl_pkg::ACT_REV: begin
                if (!ready2) begin
                    dec_st = itpl_pkg::ST_NOT_READY;
                end else begin
                    dec_kind = itpl_pkg::KIND_LOOKUP;
                end
            end
            itpl_pkg::ACT_INDEX: begin
                if (!ready1) begin
                    dec_st = itpl_pkg::ST_NOT_READY;
                end else if (7'(pidx_reg) < n) begin
                    dec_kind = itpl_pkg::KIND_TARGET;
                    dec_sel  = 1'b1;
                end else begin
                    dec_st = itpl_pkg::ST_INDEX_REJ;
                end
            end
            itpl_pkg::ACT_TWK_FWD: begin
                dec_idx = 6'(lm_reg + 7'd1);
                if (!ready2) begin
                    dec_st = itpl_pkg::ST_NOT_READY;
                end else if (!lm_reg[6] && (lm_reg < n - 7'd1)) begin
                    dec_kind = itpl_pkg::KIND_TARGET;
                    dec_sel  = 1'b1;
                end else begin
                    dec_st = itpl_pkg::ST_NO_STEP;
                end
            end
            itpl_pkg::ACT_TWK_BACK: begin
                dec_idx = 6'(lm_reg - 7'd1);
                if (!ready2) begin
                    dec_st = itpl_pkg::ST_NOT_READY;
                end else if (!lm_reg[6] && (lm_reg != 7'd0) && (lm_reg < n)) begin
                    dec_kind = itpl_pkg::KIND_TARGET;
                    dec_sel  = 1'b1;
                end else begin
                    dec_st = itpl_pkg::ST_NO_STEP;
                end
            end
            default: begin
                dec_kind = itpl_pkg::KIND_DONE;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.rd_sel)
            itpl_pkg::RD_ZERO: rd_addr = '0;
            itpl_pkg::RD_LAST: rd_addr = n_last;
            itpl_pkg::RD_WALK: rd_addr = j_reg[itpl_pkg::IDX_W-1:0];
            itpl_pkg::RD_SEG:  rd_addr = seg_reg;
            itpl_pkg::RD_SEG1: rd_addr = 6'(seg_reg + 6'd1);
            itpl_pkg::RD_TGT:  rd_addr = tgt_idx_reg;
            default:           rd_addr = '0;
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.decode && (action_reg == itpl_pkg::ACT_WRITE)) begin
            mem[pidx_reg] <= {tolin_reg, yin_reg, xin_reg};
        end
        rd_reg <= mem[rd_addr];
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        sts.kind      = dec_kind;
        sts.q_lt_key  = q_reg < key;
        sts.bracket   = (prev_reg <= q_reg) && (q_reg < key);
        sts.walk_end  = j_reg == n - 7'd1;
        sts.zero_span = magd == 32'd0;
        sts.cnt_done  = cnt_reg == '0;
        sts.out_free  = out_free;
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg <= s_tdata[2:0];
            pidx_reg   <= s_tdata[8:3];
            xin_reg    <= s_tdata[40:9];
            yin_reg    <= s_tdata[72:41];
            tolin_reg  <= s_tdata[103:73];
            q_reg      <= s_tdata[135:104];
        end
        if (cmd.decode) begin
            key_y_reg   <= action_reg == itpl_pkg::ACT_REV;
            tgt_idx_reg <= dec_idx;
        end
        if (cmd.walk_init) begin
            j_reg <= 7'd1;
        end else if (cmd.walk_inc) begin
            j_reg <= j_reg + 7'd1;
        end
        if (cmd.ld_prev) begin
            prev_reg <= key;
        end
        if (cmd.seg_first) begin
            seg_reg <= '0;
        end else if (cmd.seg_last) begin
            seg_reg <= 6'(n - 7'd2);
        end else if (cmd.seg_walk) begin
            seg_reg <= 6'(j_reg - 7'd1);
        end
        if (cmd.ld_a) begin
            ea_reg <= rd_reg;
        end
        if (cmd.ld_b) begin
            eb_reg <= rd_reg;
        end
        if (cmd.setup) begin
            m1_reg   <= mag1;
            d_reg    <= magd;
            prod_reg <= {32'd0, mag2};
            rem_reg  <= '0;
            neg_reg  <= dm1[32] ^ dm2[32] ^ dd[32];
            base_reg <= b0;
            cnt_reg  <= itpl_pkg::MUL_LAST;
        end else if (cmd.mul_step) begin
            prod_reg <= {mul_sum, prod_reg[31:1]};
            cnt_reg  <= (cnt_reg == '0) ? itpl_pkg::DIV_LAST : cnt_reg - 6'd1;
        end else if (cmd.div_step) begin
            rem_reg  <= div_ge ? 32'(div_shift - {1'b0, d_reg}) : div_shift[31:0];
            prod_reg <= {prod_reg[62:0], div_ge};
            cnt_reg  <= cnt_reg - 6'd1;
        end
    end

    // Architectural state and result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg   <= '0;
            ready_reg    <= 1'b0;
            lm_reg       <= 7'h7f;
            readback_reg <= '0;
            sel_reg      <= '0;
            st_reg       <= itpl_pkg::ST_OK;
            tv_reg       <= 1'b0;
            tgt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    itpl_pkg::REG_POINT_COUNT: pcount_reg <= cfg_data;
                    itpl_pkg::REG_TABLE_READY: ready_reg  <= cfg_data[0];
                    default:                   ready_reg  <= ready_reg;
                endcase
            end
            if (cmd.decode) begin
                st_reg  <= dec_st;
                tv_reg  <= 1'b0;
                tgt_reg <= '0;
                if (action_reg == itpl_pkg::ACT_FWD) begin
                    lm_reg <= 7'h7f;
                end
                if (dec_sel) begin
                    sel_reg <= dec_idx;
                end
            end
            if (cmd.setup) begin
                if (magd == 32'd0) begin
                    st_reg <= itpl_pkg::ST_ZERO_SPAN;
                end
                if (!key_y_reg) begin
                    if (magq0 <= {1'b0, ta}) begin
                        lm_reg <= 7'(seg_reg);
                    end else if (magq1 <= {1'b0, tb}) begin
                        lm_reg <= 7'(seg_reg) + 7'd1;
                    end
                end
            end
            if (cmd.acc) begin
                if (key_y_reg) begin
                    tgt_reg <= acc_res;
                    tv_reg  <= 1'b1;
                end else begin
                    readback_reg <= acc_res;
                end
            end
            if (cmd.ld_tgt) begin
                tgt_reg <= rd_x;
                tv_reg  <= 1'b1;
            end
            if (cmd.finish && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish && out_free) begin
            m_tdata_reg <= {7'd0, sel_reg, tv_reg, tgt_reg, lm_reg, readback_reg, st_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/itpl_ctrl.sv =====
// Controller: sequences decode, table walk, interpolation and result hand-off.
`timescale 1ns / 1ps

module itpl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  itpl_pkg::sts_t  sts,
    output itpl_pkg::cmd_t  cmd
);

    itpl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= itpl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itpl_pkg::S_IDLE:   if (s_tvalid) state_next = itpl_pkg::S_DECODE;
            itpl_pkg::S_DECODE: begin
                unique case (sts.kind)
                    itpl_pkg::KIND_LOOKUP: state_next = itpl_pkg::S_RD0;
                    itpl_pkg::KIND_TARGET: state_next = itpl_pkg::S_TGT_RD;
                    default:               state_next = itpl_pkg::S_FINISH;
                endcase
            end
            itpl_pkg::S_RD0:    state_next = itpl_pkg::S_CK0;
            itpl_pkg::S_CK0:    state_next = sts.q_lt_key ? itpl_pkg::S_SEGA : itpl_pkg::S_RDL;
            itpl_pkg::S_RDL:    state_next = itpl_pkg::S_CKL;
            itpl_pkg::S_CKL:    state_next = sts.q_lt_key ? itpl_pkg::S_WRD : itpl_pkg::S_SEGA;
            itpl_pkg::S_WRD:    state_next = itpl_pkg::S_WCK;
            itpl_pkg::S_WCK: begin
                if (sts.bracket || sts.walk_end) begin
                    state_next = itpl_pkg::S_SEGA;
                end else begin
                    state_next = itpl_pkg::S_WRD;
                end
            end
            itpl_pkg::S_SEGA:   state_next = itpl_pkg::S_SEGB;
            itpl_pkg::S_SEGB:   state_next = itpl_pkg::S_SEGC;
            itpl_pkg::S_SEGC:   state_next = itpl_pkg::S_SETUP;
            itpl_pkg::S_SETUP:  state_next = sts.zero_span ? itpl_pkg::S_FINISH : itpl_pkg::S_MUL;
            itpl_pkg::S_MUL:    if (sts.cnt_done) state_next = itpl_pkg::S_DIV;
            itpl_pkg::S_DIV:    if (sts.cnt_done) state_next = itpl_pkg::S_ACC;
            itpl_pkg::S_ACC:    state_next = itpl_pkg::S_FINISH;
            itpl_pkg::S_TGT_RD: state_next = itpl_pkg::S_TGT;
            itpl_pkg::S_TGT:    state_next = itpl_pkg::S_FINISH;
            itpl_pkg::S_FINISH: if (sts.out_free) state_next = itpl_pkg::S_IDLE;
            default:            state_next = itpl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = itpl_pkg::RD_ZERO;
        s_tready   = 1'b0;
        unique case (state_reg)
            itpl_pkg::S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            itpl_pkg::S_DECODE: cmd.decode = 1'b1;
            itpl_pkg::S_RD0:    cmd.rd_sel = itpl_pkg::RD_ZERO;
            itpl_pkg::S_CK0: begin
                cmd.ld_prev   = 1'b1;
                cmd.walk_init = 1'b1;
                cmd.seg_first = sts.q_lt_key;
            end
            itpl_pkg::S_RDL:    cmd.rd_sel = itpl_pkg::RD_LAST;
            itpl_pkg::S_CKL:    cmd.seg_last = !sts.q_lt_key;
            itpl_pkg::S_WRD:    cmd.rd_sel = itpl_pkg::RD_WALK;
            itpl_pkg::S_WCK: begin
                if (sts.bracket) begin
                    cmd.seg_walk = 1'b1;
                end else if (sts.walk_end) begin
                    cmd.seg_last = 1'b1;
                end else begin
                    cmd.ld_prev  = 1'b1;
                    cmd.walk_inc = 1'b1;
                end
            end
            itpl_pkg::S_SEGA:   cmd.rd_sel = itpl_pkg::RD_SEG;
            itpl_pkg::S_SEGB: begin
                cmd.ld_a   = 1'b1;
                cmd.rd_sel = itpl_pkg::RD_SEG1;
            end
            itpl_pkg::S_SEGC:   cmd.ld_b = 1'b1;
            itpl_pkg::S_SETUP:  cmd.setup = 1'b1;
            itpl_pkg::S_MUL:    cmd.mul_step = 1'b1;
            itpl_pkg::S_DIV:    cmd.div_step = 1'b1;
            itpl_pkg::S_ACC:    cmd.acc = 1'b1;
            itpl_pkg::S_TGT_RD: cmd.rd_sel = itpl_pkg::RD_TGT;
            itpl_pkg::S_TGT:    cmd.ld_tgt = 1'b1;
            itpl_pkg::S_FINISH: cmd.finish = 1'b1;
            default:            cmd.finish = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/interp_table_position_lookup.sv =====
// Top level of the piecewise-linear interpolation lookup table.
//
//   port group   dir  payload
//   s_*          in   action, point_index, x_entry, y_entry, tolerance_entry, query
//   m_*          out  status, readback, match_index, target_value, target_valid,
//                     selected_point
//   cfg_*        in   point_count (index 0), table_ready (index 1)
//
// One transaction at a time. Forward and reverse lookups may walk the n points in use
// linearly over the table memory, which has a single read port, then run the 32-step
// shift-add multiplier and the 64-step restoring divider; a zero span skips both.
// A result waiting on m_tready does not block the next input, but the next result
// holds in the finish state until the output register is free. Table memory is not
// cleared by reset.
`timescale 1ns / 1ps
`include "interp_table_position_lookup_defines.svh"

module interp_table_position_lookup (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action[2:0], point_index[8:3], x_entry[40:9], y_entry[72:41],
    // tolerance_entry[103:73], query[135:104]
    input  logic [itpl_pkg::IN_W-1:0]        s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], readback[34:3], match_index[41:35], target_value[73:42],
    // target_valid[74], selected_point[80:75], zero pad
    output logic [itpl_pkg::OUT_W-1:0]       m_tdata,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [itpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    itpl_pkg::cmd_t cmd;
    itpl_pkg::sts_t sts;

    itpl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itpl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    `ITPL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
    `ITPL_ASSERT_NOW(a_target_ok, m_tvalid && m_tdata[74], m_tdata[2:0] == itpl_pkg::ST_OK, "target with bad status")
    `ITPL_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= itpl_pkg::ST_ZERO_SPAN, "status out of range")

endmodule
